>>> rtl/ncs_pkg.sv
// Shared types and constants of the 3x3 neighbour contrast marker.
// No dependencies; ncs_window, ncs_result_fifo and the top level import it.
package ncs_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EW_W      = COL_W + 1;
  localparam int PIX_W     = 8;
  localparam int THR_W     = 8;
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 16;
  localparam int ROW_W     = 16;
  localparam int OUT_X_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int LINE_W    = 2 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd32;
  localparam logic [IMG_W_W-1:0] WIDTH_RST     = 12'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST    = 16'd480;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef struct packed {
    logic [OUT_X_W-1:0] x;
    logic [ROW_W-1:0]   y;
    logic               ink;
    logic               last;
  } result_t;

  // Request in flight between the line store read and the window update.
  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             interior;
    logic             border;
  } stage_ctl_t;

endpackage

>>> rtl/ncs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ncs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ncs_window.sv
// 3x3 sample window and the contrast test on its center.
// Depends on ncs_pkg.
module ncs_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic [ncs_pkg::PIX_W-1:0] above2,
  input  logic [ncs_pkg::PIX_W-1:0] above1,
  input  logic [ncs_pkg::PIX_W-1:0] sample,
  input  logic [ncs_pkg::THR_W-1:0] threshold,
  output logic                      ink
);
  import ncs_pkg::*;

  logic [PIX_W-1:0] win_r [3][3];
  logic [PIX_W-1:0] nbr [8];
  logic [PIX_W-1:0] center;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Neighbours as they stand after this shift; center is the old right column.
  assign center = win_r[1][2];
  assign nbr[0] = win_r[0][1];
  assign nbr[1] = win_r[1][1];
  assign nbr[2] = win_r[2][1];
  assign nbr[3] = win_r[0][2];
  assign nbr[4] = win_r[2][2];
  assign nbr[5] = above2;
  assign nbr[6] = above1;
  assign nbr[7] = sample;

  always_comb begin
    ink = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (abs_diff(nbr[i], center) > threshold) ink = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (advance) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= above2;
      win_r[1][2] <= above1;
      win_r[2][2] <= sample;
    end
  end

endmodule

>>> rtl/ncs_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
// Depends on ncs_pkg.
module ncs_result_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     push_cnt,
  input  ncs_pkg::result_t               push_d0,
  input  ncs_pkg::result_t               push_d1,
  input  logic                           pop,
  output logic                           not_empty,
  output ncs_pkg::result_t               head,
  output logic [ncs_pkg::FIFO_CNT_W-1:0] count
);
  import ncs_pkg::*;

  result_t               entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + FIFO_PTR_W'(1);
  assign not_empty  = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign count      = count_r;
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_cnt);
  assign rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
  assign count_nxt  = count_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entry_r[wr_ptr_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      entry_r[wr_ptr_p1] <= push_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/neighbour_contrast_sketch.sv
// Top level of the streaming 3x3 neighbour contrast marker.
// Depends on ncs_pkg, ncs_ram, ncs_window and ncs_result_fifo.
//
// Red samples of a frame arrive one per request in raster order. An interior
// pixel is marked ink when any of its eight neighbours differs from it by more
// than the threshold; border pixels are always white. A border pixel's result
// leaves for the request that carries it, an interior pixel's result for the
// request one row and one column later, so each result carries its x/y and the
// last result of a request has last_of_run set (interior result first when a
// request yields two). Throughput is one request per clock while in_ready is
// high; the two line stores share one 2048 x 16 single-port-read RAM, read
// when a request is accepted and written back the next cycle, with a forward
// path for width-1 frames where the same entry is hit on consecutive cycles.
// Results wait in an 8-entry queue that drives out_valid and absorbs output
// stalls; in_ready drops when the queue could not hold two more results on
// top of the two reserved for the request still being formed. The line store
// has no reset or clearing pass: the user must see that its entries are only
// read after the frame has written them; the block does not enforce this.
// Change the configuration only while the block is idle.
module neighbour_contrast_sketch (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ncs_pkg::PIX_W-1:0]     in_red_sample,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ncs_pkg::OUT_X_W-1:0]   out_x,
  output logic [ncs_pkg::ROW_W-1:0]     out_y,
  output logic                          out_ink,
  output logic                          out_last_of_run,
  // Configuration
  input  logic                          cfg_we,
  input  logic [ncs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ncs_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import ncs_pkg::*;

  // Configuration registers
  logic [THR_W-1:0]   threshold_r;
  logic [IMG_W_W-1:0] img_width_r;
  logic [IMG_H_W-1:0] img_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      img_width_r  <= WIDTH_RST;
      img_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:    threshold_r  <= cfg_wdata[THR_W-1:0];
        REG_IMAGE_WIDTH:  img_width_r  <= cfg_wdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: img_height_r <= cfg_wdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, width clamps to the line store size.
  logic [EW_W-1:0]  eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    priority if (img_width_r == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(img_width_r) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(img_width_r);
    end
  end

  assign eff_h = (img_height_r == '0) ? ROW_W'(1) : ROW_W'(img_height_r);

  // Raster position of the next request
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_acc;
  logic             last_col, last_row;
  logic             is_interior, is_border;

  assign in_acc   = in_valid && in_ready;
  assign last_col = (EW_W'(col_r) + EW_W'(1)) >= eff_w;
  assign last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, eff_h};

  assign is_interior = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2)) &&
                       (EW_W'(col_r) < eff_w) && (row_r < eff_h);
  assign is_border   = (col_r == '0) || (row_r == '0) || last_col || last_row;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: line store data arrives, window shifts, results are formed.
  stage_ctl_t       s1_r;
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_sample_r;
  logic             fwd_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic [LINE_W-1:0] rd_data, line_word, wr_word;
  logic [PIX_W-1:0] above2, above1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      // Same entry read while the previous request writes it: take the write data.
      fwd_r      <= in_acc && s1_valid_r && (s1_r.x == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.x        <= col_r;
      s1_r.y        <= row_r;
      s1_r.interior <= is_interior;
      s1_r.border   <= is_border;
      s1_sample_r   <= in_red_sample;
      fwd_data_r    <= wr_word;
    end
  end

  ncs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_r.x),
    .wdata (wr_word),
    .raddr (col_r),
    .rdata (rd_data)
  );

  // Word layout: upper line in the high byte, middle line in the low byte.
  assign line_word = fwd_r ? fwd_data_r : rd_data;
  assign above2    = line_word[LINE_W-1:PIX_W];
  assign above1    = line_word[PIX_W-1:0];
  assign wr_word   = {above1, s1_sample_r};

  logic ink;

  ncs_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_valid_r),
    .above2    (above2),
    .above1    (above1),
    .sample    (s1_sample_r),
    .threshold (threshold_r),
    .ink       (ink)
  );

  // Assemble up to two results; the older interior pixel goes first.
  result_t          res_int, res_brd, push_d0, push_d1;
  logic [1:0]       push_cnt;
  logic             do_int, do_brd;

  assign do_int = s1_valid_r && s1_r.interior;
  assign do_brd = s1_valid_r && s1_r.border;

  always_comb begin
    res_int.x    = OUT_X_W'(s1_r.x - COL_W'(1));
    res_int.y    = s1_r.y - ROW_W'(1);
    res_int.ink  = ink;
    res_int.last = !do_brd;
    res_brd.x    = OUT_X_W'(s1_r.x);
    res_brd.y    = s1_r.y;
    res_brd.ink  = 1'b0;
    res_brd.last = 1'b1;
    push_cnt     = 2'(do_int) + 2'(do_brd);
    push_d0      = do_int ? res_int : res_brd;
    push_d1      = res_brd;
  end

  result_t               head;
  logic                  not_empty;
  logic [FIFO_CNT_W-1:0] q_count;
  logic [FIFO_CNT_W:0]   q_claim;

  ncs_result_fifo u_results (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .pop       (out_valid && out_ready),
    .not_empty (not_empty),
    .head      (head),
    .count     (q_count)
  );

  // Reserve room for two results of the request in stage 1 and two of the next.
  assign q_claim  = (FIFO_CNT_W+1)'(q_count) + (s1_valid_r ? (FIFO_CNT_W+1)'(2) : '0);
  assign in_ready = q_claim <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2);

  assign out_valid       = not_empty;
  assign out_x           = head.x;
  assign out_y           = head.y;
  assign out_ink         = head.ink;
  assign out_last_of_run = head.last;

endmodule

>>> sim/testbench.sv
// Self-checking bench for the neighbour_contrast_sketch 3x3 contrast marker.
// Holds a cycle-free predictor of the edge map and compares every result in order.
// Depends on rtl/ncs_pkg.sv and the RTL under rtl/ only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ncs_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 12;
  // Give the pipe and the queue a margin after the last expected result.
  localparam int SETTLE_CYCLES   = 6;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  // Longest legal quiet stretch is the receiver hold-off; allow several times that.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PIXELS   = 300;
  localparam int MAX_REPORTS     = 200;

  localparam logic WHITE = 1'b0;

  typedef enum int {SHADE_NOISE, SHADE_SMOOTH, SHADE_STARK} shade_e;

  // Clock, reset and stimulus, all at known values from time zero.
  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic [PIX_W-1:0]     in_red_sample   = '0;
  logic                 out_ready       = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_THRESHOLD;
  logic [CFG_DAT_W-1:0] cfg_wdata       = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic [OUT_X_W-1:0]   out_x;
  logic [ROW_W-1:0]     out_y;
  logic                 out_ink;
  logic                 out_last_of_run;

  // Predictor state: its own copy of the configuration, line stores and window.
  logic [THR_W-1:0]   cfg_threshold = THRESHOLD_RST;
  logic [IMG_W_W-1:0] cfg_width     = WIDTH_RST;
  logic [IMG_H_W-1:0] cfg_height    = HEIGHT_RST;
  logic [PIX_W-1:0]   upper_row  [MAX_WIDTH];
  logic [PIX_W-1:0]   middle_row [MAX_WIDTH];
  logic [PIX_W-1:0]   win [3][3];
  int                 pos_col = 0;
  int                 pos_row = 0;

  // Expected results, oldest first.
  result_t pending_marks [$];

  int mismatches   = 0;
  int pixels_sent  = 0;
  int idle_cycles  = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  bit hold_off_req = 1'b0;
  bit send_steady  = 1'b0;
  bit recv_steady  = 1'b0;

  neighbour_contrast_sketch dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_red_sample   (in_red_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_ink         (out_ink),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Gap lengths: mostly back to back, some short pauses, a few long ones.
  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Advance the predictor by one accepted sample and queue the results it causes:
  // the interior pixel one row and one column back (if any) ahead of the border
  // pixel that just arrived (if it is one).
  function automatic void mark_pixel(input logic [PIX_W-1:0] red);
    int w, h, col, row, idx, center, diff, r, c;
    logic [PIX_W-1:0] above2, above1;
    logic dark, at_last_col, at_last_row, has_inner, has_border;
    result_t item;
    // Out-of-range geometry: width 0 acts as 1 and clamps at the line length,
    // height 0 acts as 1.
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    col = pos_col;
    row = pos_row;
    idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;

    above2 = upper_row[idx];
    above1 = middle_row[idx];
    upper_row[idx]  = above1;
    middle_row[idx] = red;

    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = red;

    // A position at or past the last column/row counts as that last column/row.
    at_last_col = (col + 1 >= w);
    at_last_row = (row + 1 >= h);
    has_inner   = (col >= 2 && row >= 2 && col < w && row < h);
    has_border  = (col == 0 || row == 0 || at_last_col || at_last_row);

    if (has_inner) begin
      center = int'(win[1][1]);
      dark   = 1'b0;
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          if (!(r == 1 && c == 1)) begin
            diff = int'(win[r][c]) - center;
            if (diff < 0) diff = -diff;
            if (diff > int'(cfg_threshold)) dark = 1'b1;
          end
        end
      end
      item.x    = OUT_X_W'(col - 1);
      item.y    = ROW_W'(row - 1);
      item.ink  = dark;
      item.last = !has_border;
      pending_marks.push_back(item);
    end
    if (has_border) begin
      item.x    = OUT_X_W'(col);
      item.y    = ROW_W'(row);
      item.ink  = WHITE;
      item.last = 1'b1;
      pending_marks.push_back(item);
    end

    if (at_last_col) begin
      pos_col = 0;
      pos_row = at_last_row ? 0 : row + 1;
    end else begin
      pos_col = col + 1;
    end
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function automatic void check_mark();
    result_t want;
    if (pending_marks.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: unexpected result x=%0d y=%0d ink=%0d, expected none",
                 $time, out_x, out_y, out_ink);
      return;
    end
    want = pending_marks.pop_front();
    compare_field("out_x", 32'(want.x), 32'(out_x));
    compare_field("out_y", 32'(want.y), 32'(out_y));
    compare_field("out_ink", 32'(want.ink), 32'(out_ink));
    compare_field("out_last_of_run", 32'(want.last), 32'(out_last_of_run));
  endfunction

  // Result side: check every accepted result, then pick out_ready for the next
  // edge. A requested hold-off is counted out here, cycle by cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_mark();
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_OFF_CYCLES - 1;
      out_ready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap(recv_steady);
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("neighbour_contrast_sketch verification failed");
        $finish;
      end
    end
  end

  // Offer one request after a random gap and hold it until accepted. Leave
  // in_valid high afterwards so a back-to-back request never toggles it.
  task automatic push_red(input logic [PIX_W-1:0] red);
    int gap;
    gap = pick_gap(send_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_red_sample <= red;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    mark_pixel(red);
    pixels_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the pipe run empty;
  // a request with no result may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= CFG_DAT_W'(value);
    @(posedge clk);
    unique case (index)
      REG_THRESHOLD:    cfg_threshold = THR_W'(value);
      REG_IMAGE_WIDTH:  cfg_width     = IMG_W_W'(value);
      REG_IMAGE_HEIGHT: cfg_height    = IMG_H_W'(value);
      default: ;
    endcase
  endtask

  // Write all three registers back to back; only call with the block idle.
  task automatic set_geometry(input int thr, input int w, input int h);
    put_reg(REG_THRESHOLD, thr);
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] draw_red(input shade_e shade, input int base,
                                                input int spread);
    int v;
    unique case (shade)
      SHADE_NOISE:  v = $urandom_range(0, 255);
      SHADE_SMOOTH: begin
        // Jitter around a base so neighbour differences straddle the threshold.
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default:      v = $urandom_range(0, 1) ? 255 : 0;
    endcase
    return PIX_W'(v);
  endfunction

  // Stream one frame until the position wraps to the origin. With cut_at set,
  // stop after that many requests, go idle and shrink the geometry mid-frame.
  task automatic run_frame(input int thr, input int w, input int h, input shade_e shade,
                           input int cut_at, input int cut_w, input int cut_h);
    int sent, base, spread;
    set_geometry(thr, w, h);
    base   = $urandom_range(0, 255);
    spread = thr / 2 + 2;
    sent   = 0;
    do begin
      if (cut_at != 0 && sent == cut_at) begin
        settle();
        set_geometry(thr, cut_w, cut_h);
      end
      push_red(draw_red(shade, base, spread));
      sent++;
    end while (pos_col != 0 || pos_row != 0);
    settle();
  endtask

  // First request under the reset geometry (640 x 480): a plain border pixel.
  task automatic test_reset_defaults();
    push_red(8'hFF);
    settle();
  endtask

  // Width 0 and height 0 act as 1. The next position (column 1) lies past the
  // last column and row, so it must wrap; then a single-column frame exercises
  // the case where the same line store entry is hit on consecutive requests.
  task automatic test_degenerate_geometry();
    int i;
    set_geometry(THRESHOLD_RST, 0, 0);
    for (i = 0; i < 3; i++) push_red(i[0] ? 8'h00 : 8'hA5);
    settle();
    set_geometry(1, 1, 3);
    for (i = 0; i < 3; i++) push_red(PIX_W'($urandom_range(0, 255)));
    settle();
  endtask

  // Smallest frame with an interior pixel. Threshold 255 against a full-swing
  // pattern stays white; threshold 0 against a one-step difference goes ink.
  // The last request of each yields both an interior and a border result.
  task automatic test_threshold_extremes();
    int i;
    set_geometry(255, 3, 3);
    for (i = 0; i < 9; i++) push_red((i != 4 && i % 2 == 0) ? 8'hFF : 8'h00);
    settle();
    set_geometry(0, 3, 3);
    for (i = 0; i < 9; i++) push_red((i == 8) ? 8'd101 : 8'd100);
    settle();
  endtask

  // Shrink the width mid-frame while the position is past the new last column.
  task automatic test_mid_frame_width();
    run_frame($urandom_range(8, 60), 6, 6, SHADE_SMOOTH, 16, 3, 6);
  endtask

  // Maximum height, then shrink it below the current row to close the frame.
  task automatic test_tall_frame();
    run_frame($urandom_range(0, 255), 3, 65535, SHADE_NOISE, 15, 3, 2);
  endtask

  // Frames opened at an over-range width and at the full line length, cut
  // short by a mid-frame shrink while the position is past the new last column.
  task automatic test_wide_lines();
    run_frame($urandom_range(10, 50), 4095, 3, SHADE_SMOOTH, 40, 20, 3);
    run_frame($urandom_range(0, 255), MAX_WIDTH, 1, SHADE_NOISE, 25, 10, 1);
  endtask

  // Hold results off for a long stretch while requests keep coming, so the
  // result queue fills and in_ready drops; the sender then pauses for all
  // results before the next frame.
  task automatic test_output_hold_off();
    send_steady  = 1'b1;
    hold_off_req = 1'b1;
    run_frame(40, 8, 6, SHADE_SMOOTH, 0, 0, 0);
    send_steady  = 1'b0;
    run_frame($urandom_range(0, 255), 5, 4, SHADE_NOISE, 0, 0, 0);
  endtask

  // Random frames of mostly small geometry, some degenerate, some cut mid-frame.
  task automatic test_random_frames();
    int start, thr, w, h, roll, cells, cut, cut_w, cut_h;
    shade_e shade;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      roll = $urandom_range(0, 99);
      thr  = (roll < 10) ? 0 : (roll < 20) ? 255 : $urandom_range(0, 255);
      roll = $urandom_range(0, 99);
      if (roll < 8) w = 0;
      else if (roll < 20) w = $urandom_range(1, 2);
      else if (roll < 90) w = $urandom_range(3, 12);
      else w = $urandom_range(13, 40);
      roll = $urandom_range(0, 99);
      if (roll < 8) h = 0;
      else if (roll < 20) h = $urandom_range(1, 2);
      else h = $urandom_range(3, 8);
      shade       = shade_e'($urandom_range(0, 2));
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      cells = (w > 0 ? w : 1) * (h > 0 ? h : 1);
      cut   = 0;
      cut_w = w;
      cut_h = h;
      // Only shrink mid-frame: growing would read line entries never written.
      if (cells > 2 && $urandom_range(0, 4) == 0) begin
        cut   = $urandom_range(1, cells - 1);
        cut_w = $urandom_range(1, w > 0 ? w : 1);
        cut_h = $urandom_range(1, h > 0 ? h : 1);
      end
      run_frame(thr, w, h, shade, cut, cut_w, cut_h);
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  initial begin
    int i, r;
    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (r = 0; r < 3; r++) begin
      for (i = 0; i < 3; i++) win[r][i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_degenerate_geometry();
    test_threshold_extremes();
    test_mid_frame_width();
    test_tall_frame();
    test_output_hold_off();
    test_random_frames();
    test_wide_lines();

    // Everything is drained by now; watch a little longer for stray results.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_marks.size() == 0) begin
      $display("neighbour_contrast_sketch verification clean");
    end else begin
      $display("neighbour_contrast_sketch verification failed");
    end
    $finish;
  end

endmodule
